// ===== rtl/slasm_pkg.sv =====
// Shared types and constants for the serial line assembler.
// No dependencies.
package slasm_pkg;

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_RX_OVF  = 2'd2;
	localparam logic [1:0] CMD_RECOVER = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_LINE = 2'd1;
	localparam logic [1:0] ERR_RX   = 2'd2;

	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic [15:0] read_limit;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        char_valid;
		logic        last;
		logic        read_status;
		logic        line_avail;
		logic [5:0]  line_length;
		logic        fault_flag;
		logic [1:0]  fault_code;
		logic [15:0] fault_count;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0]  command;
		logic        is_eol;
		logic        is_bs;
		logic        is_print;
		logic [7:0]  data_byte;
		logic [15:0] limit_m1;
	} op_t;

endpackage

// ===== rtl/slasm_chan_if.sv =====
// Valid/ready channel carrying one request payload.
// Payload type comes from slasm_pkg.
interface slasm_chan_if #(parameter type T = slasm_pkg::in_item_t);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/slasm_front.sv =====
// Front end: accepts input requests, classifies them, two-entry queue to the back end.
// Depends on slasm_pkg and slasm_chan_if.
module slasm_front (
	input  logic              clk,
	input  logic              arst_n,
	slasm_chan_if.sink        in_ch,
	output logic              op_valid,
	input  logic              op_ready,
	output slasm_pkg::op_t    op
);

	slasm_pkg::op_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	slasm_pkg::op_t cls;
	logic           push;
	logic           pop;

	always_comb begin
		cls.command   = in_ch.data.command;
		cls.data_byte = in_ch.data.data_byte;
		cls.is_eol    = in_ch.data.data_byte inside {slasm_pkg::CH_CR, slasm_pkg::CH_LF};
		cls.is_bs     = in_ch.data.data_byte inside {slasm_pkg::CH_BS, slasm_pkg::CH_DEL};
		cls.is_print  = in_ch.data.data_byte inside
			{[slasm_pkg::CH_PRINT_LO:slasm_pkg::CH_PRINT_HI]};
		// limit zero behaves as limit one
		cls.limit_m1  = (in_ch.data.read_limit == 16'd0) ? 16'd0
			: in_ch.data.read_limit - 16'd1;
	end

	assign in_ch.ready = (fill_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign op_valid    = (fill_q != 2'd0);
	assign pop         = op_valid && op_ready;
	assign op          = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/slasm_back.sv =====
// Back end: line state, line memory, read streaming and result register.
// Depends on slasm_pkg and slasm_chan_if.
module slasm_back #(
	parameter int LINE_SIZE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  slasm_pkg::op_t    op,
	slasm_chan_if.source      out_ch
);

	localparam int DEPTH = LINE_SIZE - 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(LINE_SIZE);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [7:0]    mem [DEPTH];

	logic [CW-1:0] cnt_q, cnt_d;
	logic          rdy_q, rdy_d;
	logic          errf_q, errf_d;
	logic [1:0]    errc_q, errc_d;
	logic [15:0]   errn_q, errn_d;

	logic          stream_q, stream_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] n_q, n_d;

	logic          v_s1;
	logic          char_s1;
	logic          last_s1;
	logic          status_s1;
	logic [7:0]    rd_s1;

	logic                 o_v_q;
	slasm_pkg::out_item_t o_q;

	logic          en1, en2;
	logic          ld_v, ld_char, ld_last, ld_status, rd_en, wr_en;
	logic [CW-1:0] idx_inc;
	logic [15:0]   cnt_ext;
	logic [CW+5:0] len_ext;

	assign en2      = !o_v_q || out_ch.ready;
	assign en1      = !v_s1 || en2;
	assign op_ready = en1 && !stream_q;
	assign idx_inc  = idx_q + CW'(1);
	assign cnt_ext  = {{(16 - CW){1'b0}}, cnt_q};
	assign len_ext  = {6'd0, cnt_q};

	always_comb begin
		cnt_d     = cnt_q;
		rdy_d     = rdy_q;
		errf_d    = errf_q;
		errc_d    = errc_q;
		errn_d    = errn_q;
		stream_d  = stream_q;
		idx_d     = idx_q;
		n_d       = n_q;
		ld_v      = 1'b0;
		ld_char   = 1'b0;
		ld_last   = 1'b1;
		ld_status = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		if (stream_q) begin
			ld_v    = 1'b1;
			ld_char = 1'b1;
			rd_en   = 1'b1;
			ld_last = (idx_inc == n_q);
			idx_d   = idx_inc;
			if (idx_inc == n_q) begin
				stream_d = 1'b0;
			end
		end else if (op_valid) begin
			ld_v = 1'b1;
			case (op.command)
				slasm_pkg::CMD_BYTE: begin
					if (!rdy_q) begin
						if (op.is_eol) begin
							rdy_d = 1'b1;
						end else if (op.is_bs) begin
							if (cnt_q != '0) begin
								cnt_d = cnt_q - CW'(1);
							end
						end else if (op.is_print) begin
							if (cnt_q >= FULL) begin
								cnt_d  = '0;
								errf_d = 1'b1;
								errc_d = slasm_pkg::ERR_LINE;
								errn_d = errn_q + 16'd1;
							end else begin
								wr_en = 1'b1;
								cnt_d = cnt_q + CW'(1);
							end
						end
					end
				end
				slasm_pkg::CMD_READ: begin
					if (!rdy_q) begin
						ld_status = 1'b1;
					end else begin
						cnt_d = '0;
						rdy_d = 1'b0;
						if (op.limit_m1 < cnt_ext) begin
							n_d = op.limit_m1[CW-1:0];
						end else begin
							n_d = cnt_q;
						end
						if (n_d != '0) begin
							ld_v     = 1'b0;
							stream_d = 1'b1;
							idx_d    = '0;
						end
					end
				end
				slasm_pkg::CMD_RX_OVF: begin
					cnt_d  = '0;
					rdy_d  = 1'b0;
					errf_d = 1'b1;
					errc_d = slasm_pkg::ERR_RX;
					errn_d = errn_q + 16'd1;
				end
				slasm_pkg::CMD_RECOVER: begin
					cnt_d  = '0;
					rdy_d  = 1'b0;
					errf_d = 1'b0;
					errc_d = slasm_pkg::ERR_NONE;
					errn_d = 16'd0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && wr_en) begin
			mem[cnt_q[AW-1:0]] <= op.data_byte;
		end
		if (en1 && rd_en) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rdy_q    <= 1'b0;
			errf_q   <= 1'b0;
			errc_q   <= slasm_pkg::ERR_NONE;
			errn_q   <= 16'd0;
			stream_q <= 1'b0;
			idx_q    <= '0;
			n_q      <= '0;
			v_s1     <= 1'b0;
		end else if (en1) begin
			cnt_q    <= cnt_d;
			rdy_q    <= rdy_d;
			errf_q   <= errf_d;
			errc_q   <= errc_d;
			errn_q   <= errn_d;
			stream_q <= stream_d;
			idx_q    <= idx_d;
			n_q      <= n_d;
			v_s1     <= ld_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			char_s1   <= ld_char;
			last_s1   <= ld_last;
			status_s1 <= ld_status;
		end
	end

	// state fields are sampled as the request leaves s1; state only moves when s1 refills
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			o_q.out_char    <= char_s1 ? rd_s1 : 8'd0;
			o_q.char_valid  <= char_s1;
			o_q.last        <= last_s1;
			o_q.read_status <= status_s1;
			o_q.line_avail  <= rdy_q;
			o_q.line_length <= len_ext[5:0];
			o_q.fault_flag  <= errf_q;
			o_q.fault_code  <= errc_q;
			o_q.fault_count <= errn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (en2) begin
			o_v_q <= v_s1;
		end
	end

	assign out_ch.valid = o_v_q;
	assign out_ch.data  = o_q;

endmodule

// ===== rtl/serial_line_assembler.sv =====
// Serial line assembler top level: front queue plus back end.
// Depends on slasm_pkg, slasm_chan_if, slasm_front, slasm_back.
//
// in_ch carries one request per handshake: a received byte, a read, a receiver
// overflow event or a recover. out_ch carries results; every request gives one
// result, except a read of a ready line, which gives one result per character
// copied (at most read_limit-1), with last set on the final one, or one result
// if none is. One request per cycle is sustained while out_ch is ready and no
// read streams; a read streams its characters at one per cycle from the line
// memory read port while out_ch is ready, after a setup step. A two-deep
// request queue decouples input from the back end, and a result register lets
// input keep flowing for a few requests while out_ch stalls. When the receiver
// stalls, the result is held and the back end halts; the queue fills and
// in_ch.ready then drops. Reset clears the line and error state; the line
// memory is not cleared and needs no clearing pass.
module serial_line_assembler #(
	parameter int LINE_SIZE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	slasm_chan_if.sink   in_ch,
	slasm_chan_if.source out_ch
);

	logic           op_valid;
	logic           op_ready;
	slasm_pkg::op_t op;

	slasm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	slasm_back #(
		.LINE_SIZE (LINE_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op),
		.out_ch   (out_ch)
	);

endmodule

// ===== rtl/slasm_checker.sv =====
// Port-level checks for the serial line assembler, bound to the top level.
// Depends on slasm_pkg and serial_line_assembler.
module slasm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input slasm_pkg::out_item_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.char_valid |-> out_data.out_char == 8'd0)
		else $error("out_char set without char_valid");

	a_stream_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.char_valid |->
			!out_data.line_avail && out_data.line_length == 6'd0 && !out_data.read_status)
		else $error("streamed character with uncleared line");

	a_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.fault_flag |->
			out_data.fault_code == slasm_pkg::ERR_NONE && out_data.fault_count == 16'd0)
		else $error("error fields set without error flag");

endmodule

bind serial_line_assembler slasm_checker u_slasm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for serial_line_assembler: directed, overflow, stall and random requests.
// Depends on slasm_pkg, slasm_chan_if and the serial_line_assembler RTL.
module tb;

	localparam int LINE_SIZE = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	slasm_chan_if #(.T(slasm_pkg::in_item_t))  in_ch ();
	slasm_chan_if #(.T(slasm_pkg::out_item_t)) out_ch ();

	serial_line_assembler #(.LINE_SIZE(LINE_SIZE)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// line and error state as the block should hold it
	logic [7:0]  ln_buf [LINE_SIZE];
	int unsigned ln_len = 0;
	logic        ln_done = 1'b0;
	logic        err_seen = 1'b0;
	logic [1:0]  err_code = slasm_pkg::ERR_NONE;
	logic [15:0] err_total = '0;

	slasm_pkg::out_item_t results_due [$];

	int send_idle_pct = 7;
	int recv_idle_pct = 72;
	int hold_left = 0;
	int fail_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int reads_seen = 0;
	int chars_streamed = 0;

	function automatic void push_result(input logic [7:0] ch, input logic valid,
			input logic fin, input logic status);
		slasm_pkg::out_item_t r;
		r.out_char    = ch;
		r.char_valid  = valid;
		r.last        = fin;
		r.read_status = status;
		r.line_avail  = ln_done;
		r.line_length = 6'(ln_len);
		r.fault_flag  = err_seen;
		r.fault_code  = err_code;
		r.fault_count = err_total;
		results_due.push_back(r);
	endfunction

	function automatic void note_error(input logic [1:0] code);
		ln_len    = 0;
		ln_done   = 1'b0;
		err_seen  = 1'b1;
		err_code  = code;
		err_total = err_total + 16'd1;
	endfunction

	function automatic void apply_request(input slasm_pkg::in_item_t req);
		int unsigned lim;
		int unsigned n;
		logic [7:0] b;
		b = req.data_byte;
		case (req.command)
		slasm_pkg::CMD_READ: begin
			reads_seen++;
			if (!ln_done) begin
				push_result(8'h00, 1'b0, 1'b1, 1'b1);
			end else begin
				lim = (req.read_limit == 16'd0) ? 1 : req.read_limit;
				n = (ln_len >= lim) ? lim - 1 : ln_len;
				ln_len  = 0;
				ln_done = 1'b0;
				if (n == 0) begin
					push_result(8'h00, 1'b0, 1'b1, 1'b0);
				end else begin
					for (int i = 0; i < n; i++)
						push_result(ln_buf[i], 1'b1, i == n - 1, 1'b0);
				end
				chars_streamed += n;
			end
		end
		slasm_pkg::CMD_BYTE: begin
			if (ln_done) begin
				// ignored while a line waits
			end else if (b == slasm_pkg::CH_CR || b == slasm_pkg::CH_LF) begin
				ln_done = 1'b1;
			end else if (b == slasm_pkg::CH_BS || b == slasm_pkg::CH_DEL) begin
				if (ln_len > 0)
					ln_len--;
			end else if (b >= slasm_pkg::CH_PRINT_LO && b <= slasm_pkg::CH_PRINT_HI) begin
				if (ln_len >= LINE_SIZE - 1) begin
					note_error(slasm_pkg::ERR_LINE);
				end else begin
					ln_buf[ln_len] = b;
					ln_len++;
				end
			end
			push_result(8'h00, 1'b0, 1'b1, 1'b0);
		end
		slasm_pkg::CMD_RX_OVF: begin
			note_error(slasm_pkg::ERR_RX);
			push_result(8'h00, 1'b0, 1'b1, 1'b0);
		end
		default: begin
			ln_len    = 0;
			ln_done   = 1'b0;
			err_seen  = 1'b0;
			err_code  = slasm_pkg::ERR_NONE;
			err_total = '0;
			push_result(8'h00, 1'b0, 1'b1, 1'b0);
		end
		endcase
	endfunction

	function automatic void cmp_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_result(input slasm_pkg::out_item_t got);
		slasm_pkg::out_item_t want;
		if (results_due.size() == 0) begin
			$error("result with nothing pending: %p", got);
			fail_count++;
		end else begin
			want = results_due.pop_front();
			checked_count++;
			cmp_field("out_char", 16'(want.out_char), 16'(got.out_char));
			cmp_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
			cmp_field("last", 16'(want.last), 16'(got.last));
			cmp_field("read_status", 16'(want.read_status), 16'(got.read_status));
			cmp_field("line_avail", 16'(want.line_avail), 16'(got.line_avail));
			cmp_field("line_length", 16'(want.line_length), 16'(got.line_length));
			cmp_field("fault_flag", 16'(want.fault_flag), 16'(got.fault_flag));
			cmp_field("fault_code", 16'(want.fault_code), 16'(got.fault_code));
			cmp_field("fault_count", want.fault_count, got.fault_count);
		end
	endfunction

	// result side: check on handshake, then pick next ready
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				check_result(out_ch.data);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_req(input slasm_pkg::in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= req;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		apply_request(req);
		sent_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_req(slasm_pkg::in_item_t'{slasm_pkg::CMD_BYTE, b, 16'($urandom)});
	endtask

	task automatic send_read(input logic [15:0] lim);
		send_req(slasm_pkg::in_item_t'{slasm_pkg::CMD_READ, 8'($urandom), lim});
	endtask

	task automatic send_cmd(input logic [1:0] cmd);
		send_req(slasm_pkg::in_item_t'{cmd, 8'($urandom), 16'($urandom)});
	endtask

	task automatic type_chars(input int n);
		repeat (n)
			send_byte(8'($urandom_range(slasm_pkg::CH_PRINT_LO, slasm_pkg::CH_PRINT_HI)));
	endtask

	function automatic logic [15:0] rand_limit();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 16'($urandom_range(1, 70));
		else if (r < 80)
			return 16'($urandom);
		else if (r < 90)
			return 16'($urandom_range(0, 1));
		else
			return 16'($urandom_range(62, 64));
	endfunction

	task automatic test_directed();
		send_read(16'd10);
		send_byte(slasm_pkg::CH_BS);
		send_byte(slasm_pkg::CH_DEL);
		send_byte(slasm_pkg::CH_CR);
		send_byte("A");
		send_byte(slasm_pkg::CH_LF);
		send_byte(slasm_pkg::CH_BS);
		send_read(16'd5);
		send_byte(slasm_pkg::CH_PRINT_LO);
		send_byte(slasm_pkg::CH_PRINT_HI);
		send_byte(8'h1F);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(slasm_pkg::CH_DEL);
		send_byte("x");
		send_byte(slasm_pkg::CH_LF);
		send_read(16'd0);
		send_byte("a");
		send_byte(slasm_pkg::CH_CR);
		send_read(16'd1);
		send_byte("h");
		send_byte("i");
		send_byte(slasm_pkg::CH_CR);
		send_read(16'hFFFF);
		send_byte("z");
		send_byte(slasm_pkg::CH_CR);
		send_cmd(slasm_pkg::CMD_RX_OVF);
		send_cmd(slasm_pkg::CMD_RECOVER);
		send_read(16'd2);
	endtask

	task automatic test_line_overflow();
		type_chars(LINE_SIZE - 1);
		type_chars(1);
		type_chars(LINE_SIZE - 1);
		send_byte(slasm_pkg::CH_CR);
		send_read(16'(LINE_SIZE));
		type_chars(LINE_SIZE - 1);
		send_byte(slasm_pkg::CH_BS);
		type_chars(1);
		send_byte(slasm_pkg::CH_LF);
		send_read(16'd30);
	endtask

	// long receiver hold-off so the request queue fills and input stalls
	task automatic test_input_stall();
		hold_left = 300;
		type_chars(30);
		send_byte(slasm_pkg::CH_LF);
		send_read(16'hFFFF);
		type_chars(8);
		send_cmd(slasm_pkg::CMD_RX_OVF);
	endtask

	task automatic send_line_seq();
		int len;
		int r;
		r = $urandom_range(99);
		if (r < 75)
			len = $urandom_range(0, 10);
		else if (r < 95)
			len = $urandom_range(11, 40);
		else
			len = $urandom_range(41, 66);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 8)
				send_byte($urandom_range(1) ? slasm_pkg::CH_BS : slasm_pkg::CH_DEL);
			else if (r < 12)
				send_byte(8'($urandom));
			else if (r < 13)
				send_cmd(slasm_pkg::CMD_RX_OVF);
			else
				type_chars(1);
		end
		if ($urandom_range(99) < 95)
			send_byte($urandom_range(1) ? slasm_pkg::CH_CR : slasm_pkg::CH_LF);
		if ($urandom_range(99) < 20)
			send_byte(8'($urandom));
		send_read(rand_limit());
	endtask

	task automatic test_random(input int n);
		int start;
		int r;
		start = sent_count;
		while (sent_count - start < n) begin
			r = $urandom_range(99);
			if (r < 70)
				send_line_seq();
			else if (r < 82)
				send_byte(8'($urandom));
			else if (r < 90)
				send_read(rand_limit());
			else if (r < 97)
				send_cmd(slasm_pkg::CMD_RX_OVF);
			else
				send_cmd(slasm_pkg::CMD_RECOVER);
		end
	endtask

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_line_overflow();
		test_input_stall();
		test_random(15);
		send_idle_pct = 72;
		recv_idle_pct = 7;
		test_random(15);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(15);
		in_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran directed cases, line overflow, input stall and three idle mixes.");
		$display("%0d requests, %0d reads, %0d chars streamed, %0d results checked.",
			sent_count, reads_seen, chars_streamed, checked_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Timeout waiting for requests or results");
		$display("Test completed with failures");
		$finish;
	end

endmodule
